>>> design/nrsp_pkg.sv
// shared constants and helpers for the rmc sentence parser
`timescale 1ns / 1ps

package nrsp_pkg;

	// default maximum characters in one text field
	localparam int FIELD_CHARS_DEF = 15;

	// text fields captured per sentence, words over all fields and bytes per word
	localparam int SLOT_COUNT  = 5;
	localparam int SLOT_WORDS  = 2 * SLOT_COUNT;
	localparam int WORD_BYTES  = 8;

	// pattern positions
	localparam logic [4:0] P_PREFIX = 5'd0;
	localparam logic [4:0] P_TIME   = 5'd7;
	localparam logic [4:0] P_STATUS = 5'd8;
	localparam logic [4:0] P_C1     = 5'd9;
	localparam logic [4:0] P_LAT    = 5'd10;
	localparam logic [4:0] P_LATDIR = 5'd11;
	localparam logic [4:0] P_C2     = 5'd12;
	localparam logic [4:0] P_LON    = 5'd13;
	localparam logic [4:0] P_LONDIR = 5'd14;
	localparam logic [4:0] P_C3     = 5'd15;
	localparam logic [4:0] P_SPEED  = 5'd16;
	localparam logic [4:0] P_HEAD   = 5'd17;
	localparam logic [4:0] P_DATE   = 5'd18;
	localparam logic [4:0] P_C4     = 5'd19;
	localparam logic [4:0] P_C5     = 5'd20;
	localparam logic [4:0] P_MODE   = 5'd21;
	localparam logic [4:0] P_DONE   = 5'd22;

	// field slots
	localparam logic [2:0] SLOT_TIME  = 3'd0;
	localparam logic [2:0] SLOT_LAT   = 3'd1;
	localparam logic [2:0] SLOT_LON   = 3'd2;
	localparam logic [2:0] SLOT_SPEED = 3'd3;
	localparam logic [2:0] SLOT_HEAD  = 3'd4;

	// characters
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ACTIVE = 8'h41;
	localparam logic [7:0] CH_NOFIX  = 8'h4E;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// output word numbers and lengths
	localparam logic [3:0] WORD_FIRST = 4'd0;
	localparam logic [3:0] WORD_DIRS  = 4'd10;
	localparam logic [3:0] DIRS_LEN   = 4'd2;
	localparam logic [3:0] LEN_MAX    = 4'd15;

	// literal sentence prefix "$GPRMC,"
	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h24;
			3'd1: c = 8'h47;
			3'd2: c = 8'h50;
			3'd3: c = 8'h52;
			3'd4: c = 8'h4D;
			3'd5: c = 8'h43;
			3'd6: c = 8'h2C;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> design/nmea_rmc_sentence_parser.sv
// rmc sentence parser: byte matcher, field capture and result sequencer
`timescale 1ns / 1ps

// Takes one sentence byte per cycle on the slave stream while no result run
// is pending, and matches it against "$GPRMC,", time, status, lat, lat
// direction, lon, lon direction, speed, heading, a skipped date, ",,," and
// the mode byte, capturing the text fields into registers as they pass.
// On the byte marked tlast the block sends a run of results on the master
// stream: one failure word, or eleven words (five fields of two words each,
// then the direction word) when the status is 'A' and the mode is not 'N'.
// The slave side is held off while a run is being loaded into the output
// register, one word per cycle the output side accepts. The next sentence
// may start as soon as the last word of a run sits in the output register.
module nmea_rmc_sentence_parser #(
	parameter int FIELD_CHARS = nrsp_pkg::FIELD_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic        s_tlast,   // end_of_sentence
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [3:0] word_index, [67:4] word_data, [71:68] text_length
	output logic        m_tuser,   // [0] fix_valid
	output logic        m_tlast    // last_word
);

	import nrsp_pkg::*;

	localparam int CW = $clog2(FIELD_CHARS + 1);

	// parser state
	logic [4:0]    pos_q;
	logic [CW-1:0] cnt_q;
	logic          fail_q;
	logic [7:0]    status_q;
	logic [7:0]    mode_q;
	logic [7:0]    latdir_q;
	logic [7:0]    londir_q;
	logic [CW-1:0] len_q [SLOT_COUNT];
	logic [7:0]    text_q [SLOT_WORDS][WORD_BYTES];

	// result run state
	logic          run_q;
	logic          ok_q;
	logic [3:0]    widx_q;

	// next-state values
	logic [4:0]    nx_pos;
	logic [CW-1:0] nx_cnt;
	logic          nx_fail;
	logic [7:0]    nx_status;
	logic [7:0]    nx_mode;
	logic [7:0]    nx_latdir;
	logic [7:0]    nx_londir;
	logic          is_text;
	logic [2:0]    txt_slot;
	logic [4:0]    txt_next;
	logic          len_we;
	logic          txt_we;

	logic          in_acc;
	logic          load;
	logic          sent_ok;

	assign s_tready = !run_q;
	assign in_acc   = s_tvalid && s_tready;
	assign load     = run_q && (!m_tvalid || m_tready);

	// byte matcher
	always_comb begin
		nx_pos    = pos_q;
		nx_cnt    = cnt_q;
		nx_fail   = fail_q;
		nx_status = status_q;
		nx_mode   = mode_q;
		nx_latdir = latdir_q;
		nx_londir = londir_q;
		is_text   = 1'b0;
		txt_slot  = SLOT_TIME;
		txt_next  = P_STATUS;
		len_we    = 1'b0;
		txt_we    = 1'b0;
		if (!fail_q && pos_q != P_DONE) begin
			if (s_tdata == CH_NUL) begin
				nx_fail = 1'b1;
			end else if (pos_q < P_TIME) begin
				if (s_tdata == prefix_char(pos_q[2:0])) begin
					nx_pos = pos_q + 5'd1;
				end else begin
					nx_fail = 1'b1;
				end
			end else begin
				case (pos_q)
					P_TIME: begin
						is_text  = 1'b1;
						txt_slot = SLOT_TIME;
						txt_next = P_STATUS;
					end
					P_STATUS: begin
						nx_status = s_tdata;
						nx_pos    = P_C1;
					end
					P_LAT: begin
						is_text  = 1'b1;
						txt_slot = SLOT_LAT;
						txt_next = P_LATDIR;
					end
					P_LATDIR: begin
						nx_latdir = s_tdata;
						nx_pos    = P_C2;
					end
					P_LON: begin
						is_text  = 1'b1;
						txt_slot = SLOT_LON;
						txt_next = P_LONDIR;
					end
					P_LONDIR: begin
						nx_londir = s_tdata;
						nx_pos    = P_C3;
					end
					P_SPEED: begin
						is_text  = 1'b1;
						txt_slot = SLOT_SPEED;
						txt_next = P_HEAD;
					end
					P_HEAD: begin
						is_text  = 1'b1;
						txt_slot = SLOT_HEAD;
						txt_next = P_DATE;
					end
					P_DATE: begin
						if (s_tdata == CH_COMMA) begin
							if (cnt_q == '0) begin
								nx_fail = 1'b1;
							end else begin
								nx_cnt = '0;
								nx_pos = P_C4;
							end
						end else begin
							nx_cnt = CW'(1);
						end
					end
					P_C1, P_C2, P_C3, P_C4, P_C5: begin
						if (s_tdata == CH_COMMA) begin
							nx_pos = pos_q + 5'd1;
						end else begin
							nx_fail = 1'b1;
						end
					end
					P_MODE: begin
						nx_mode = s_tdata;
						nx_pos  = P_DONE;
					end
					default: nx_fail = 1'b1;
				endcase
				// text field capture
				if (is_text) begin
					if (s_tdata == CH_COMMA) begin
						if (cnt_q == '0) begin
							nx_fail = 1'b1;
						end else begin
							len_we = 1'b1;
							nx_cnt = '0;
							nx_pos = txt_next;
						end
					end else if (cnt_q >= CW'(FIELD_CHARS)) begin
						nx_fail = 1'b1;
					end else begin
						txt_we = 1'b1;
						nx_cnt = cnt_q + CW'(1);
					end
				end
			end
		end
	end

	assign sent_ok = !nx_fail && nx_pos == P_DONE && nx_status == CH_ACTIVE
		&& nx_mode != CH_NOFIX;

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= P_PREFIX;
			cnt_q    <= '0;
			fail_q   <= 1'b0;
			status_q <= '0;
			mode_q   <= '0;
			latdir_q <= '0;
			londir_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				len_q[i] <= '0;
			end
		end else if (in_acc) begin
			status_q <= nx_status;
			mode_q   <= nx_mode;
			latdir_q <= nx_latdir;
			londir_q <= nx_londir;
			if (len_we) begin
				len_q[txt_slot] <= cnt_q;
			end
			if (s_tlast) begin
				pos_q  <= P_PREFIX;
				cnt_q  <= '0;
				fail_q <= 1'b0;
			end else begin
				pos_q  <= nx_pos;
				cnt_q  <= nx_cnt;
				fail_q <= nx_fail;
			end
		end
	end

	// field text store, one byte written per accepted character
	always_ff @(posedge clk) begin
		if (in_acc && txt_we) begin
			text_q[{txt_slot, cnt_q[3]}][cnt_q[2:0]] <= s_tdata;
		end
	end

	// result run control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			ok_q   <= 1'b0;
			widx_q <= WORD_FIRST;
		end else if (in_acc && s_tlast) begin
			run_q  <= 1'b1;
			ok_q   <= sent_ok;
			widx_q <= WORD_FIRST;
		end else if (load) begin
			widx_q <= widx_q + 4'd1;
			if (!ok_q || widx_q == WORD_DIRS) begin
				run_q <= 1'b0;
			end
		end
	end

	// word assembly for the current run position
	logic [2:0]    rd_slot;
	logic [CW-1:0] rd_len;
	logic [63:0]   rd_word;
	logic [3:0]    rd_len_sat;

	assign rd_slot    = widx_q[3:1];
	assign rd_len     = (rd_slot < 3'(SLOT_COUNT)) ? len_q[rd_slot] : '0;
	assign rd_len_sat = (rd_len > CW'(LEN_MAX)) ? LEN_MAX : rd_len[3:0];

	always_comb begin
		rd_word = '0;
		if (widx_q < WORD_DIRS) begin
			for (int k = 0; k < WORD_BYTES; k++) begin
				if ({1'b0, widx_q[0], 3'(k)} < 5'(rd_len)) begin
					rd_word[8*k +: 8] = text_q[widx_q][k];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (!ok_q) begin
				m_tdata <= '0;
				m_tuser <= 1'b0;
				m_tlast <= 1'b1;
			end else if (widx_q == WORD_DIRS) begin
				m_tdata <= {DIRS_LEN, 48'd0, londir_q, latdir_q, WORD_DIRS};
				m_tuser <= 1'b1;
				m_tlast <= 1'b1;
			end else begin
				m_tdata <= {rd_len_sat, rd_word, widx_q};
				m_tuser <= 1'b1;
				m_tlast <= 1'b0;
			end
		end
	end

endmodule

>>> verif/nmea_rmc_sentence_parser_test.sv
// self-checking testbench for the rmc sentence parser with a built-in parser model
`timescale 1ns / 1ps

module nmea_rmc_sentence_parser_test;
	import nrsp_pkg::*;

	localparam int FIELD_CHARS = FIELD_CHARS_DEF;
	localparam logic [55:0] PREFIX_TEXT = "$GPRMC,";
	localparam int RANDOM_ITEMS = 310;
	localparam int DRAIN_CYCLES = 20;

	// one result word as the block reports it
	typedef struct packed {
		logic [3:0]  index;
		logic [63:0] data;
		logic [3:0]  length;
		logic        fix;
		logic        last;
	} rmc_word_t;

	// one byte request with its pacing
	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       drain;
		int         gap;
	} byte_req_t;

	// shape of one generated sentence
	typedef struct packed {
		logic [4:0][4:0] len;
		logic [3:0]      date_len;
		logic [7:0]      status;
		logic [7:0]      lat_d;
		logic [7:0]      lon_d;
		logic [7:0]      mode;
		logic [2:0]      tail;
		logic [7:0]      fill;
	} rmc_spec_t;

	typedef enum int {
		FLAW_NONE,
		FLAW_LITERAL,
		FLAW_ZERO,
		FLAW_EARLY_END,
		FLAW_EMPTY_FIELD,
		FLAW_LONG_FIELD,
		FLAW_EMPTY_DATE
	} rmc_flaw_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] byte_in
	logic        s_tlast = 1'b0;    // end_of_sentence
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;           // [3:0] word_index, [67:4] word_data, [71:68] text_length
	logic        m_tuser;           // [0] fix_valid
	logic        m_tlast;           // last_word

	byte_req_t   byte_reqs[$];
	rmc_word_t   rmc_words_due[$];
	byte_req_t   staged_req;
	bit          req_staged = 1'b0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          rx_phase_left = 0;
	bit          rx_burst = 1'b0;
	int          error_count = 0;
	int          queued_items = 0;

	// parser model state
	logic [4:0]  pm_pos;
	int          pm_count;
	logic [7:0]  pm_text [SLOT_COUNT][FIELD_CHARS];
	int          pm_len [SLOT_COUNT];
	logic [7:0]  pm_lat_dir;
	logic [7:0]  pm_lon_dir;
	logic [7:0]  pm_status;
	logic [7:0]  pm_mode;
	bit          pm_failed;

	nmea_rmc_sentence_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// text field content, any byte but comma and nul
	function automatic logic [7:0] text_char(input logic [7:0] fill);
		logic [7:0] c;
		if (fill != CH_NUL) return fill;
		if ($urandom_range(0, 9) < 6) return 8'h30 + 8'($urandom_range(0, 9));
		c = 8'($urandom_range(1, 255));
		if (c == CH_COMMA) c = 8'h2E;
		return c;
	endfunction

	// text field capture, moves on at the closing comma
	task automatic take_field(input logic [7:0] b, input int slot, input logic [4:0] next_pos);
		if (b == CH_COMMA) begin
			if (pm_count == 0) begin
				pm_failed = 1'b1;
			end else begin
				pm_len[slot] = pm_count;
				pm_count = 0;
				pm_pos = next_pos;
			end
		end else if (pm_count >= FIELD_CHARS) begin
			pm_failed = 1'b1;
		end else begin
			pm_text[slot][pm_count] = b;
			pm_count++;
		end
	endtask

	task automatic need_comma(input logic [7:0] b, input logic [4:0] next_pos);
		if (b == CH_COMMA) pm_pos = next_pos;
		else pm_failed = 1'b1;
	endtask

	// pattern matcher for one byte
	task automatic match_rmc_byte(input logic [7:0] b);
		if (!pm_failed && pm_pos != P_DONE) begin
			if (b == CH_NUL) begin
				pm_failed = 1'b1;
			end else if (pm_pos < P_TIME) begin
				if (b == PREFIX_TEXT[8 * (6 - int'(pm_pos)) +: 8]) pm_pos = pm_pos + 5'd1;
				else pm_failed = 1'b1;
			end else begin
				case (pm_pos)
					P_TIME:   take_field(b, SLOT_TIME, P_STATUS);
					P_STATUS: begin
						pm_status = b;
						pm_pos = P_C1;
					end
					P_C1:     need_comma(b, P_LAT);
					P_LAT:    take_field(b, SLOT_LAT, P_LATDIR);
					P_LATDIR: begin
						pm_lat_dir = b;
						pm_pos = P_C2;
					end
					P_C2:     need_comma(b, P_LON);
					P_LON:    take_field(b, SLOT_LON, P_LONDIR);
					P_LONDIR: begin
						pm_lon_dir = b;
						pm_pos = P_C3;
					end
					P_C3:     need_comma(b, P_SPEED);
					P_SPEED:  take_field(b, SLOT_SPEED, P_HEAD);
					P_HEAD:   take_field(b, SLOT_HEAD, P_DATE);
					P_DATE: begin
						if (b == CH_COMMA) begin
							if (pm_count == 0) begin
								pm_failed = 1'b1;
							end else begin
								pm_count = 0;
								pm_pos = P_C4;
							end
						end else begin
							pm_count = 1;
						end
					end
					P_C4:     need_comma(b, P_C5);
					P_C5:     need_comma(b, P_MODE);
					P_MODE: begin
						pm_mode = b;
						pm_pos = P_DONE;
					end
					default:  pm_failed = 1'b1;
				endcase
			end
		end
	endtask

	// expected words for one accepted byte request
	task automatic predict_rmc_item(input logic [7:0] b, input logic last);
		rmc_word_t w;
		int wi, k, c, slot;
		match_rmc_byte(b);
		if (last) begin
			if (pm_failed || pm_pos != P_DONE || pm_status != CH_ACTIVE || pm_mode == CH_NOFIX) begin
				w = '{index: WORD_FIRST, data: 64'd0, length: 4'd0, fix: 1'b0, last: 1'b1};
				rmc_words_due.push_back(w);
			end else begin
				for (wi = 0; wi < SLOT_WORDS; wi++) begin
					slot = wi / 2;
					w.index = 4'(wi);
					w.data = '0;
					for (k = 0; k < WORD_BYTES; k++) begin
						c = (wi % 2) * WORD_BYTES + k;
						if (c < pm_len[slot] && c < FIELD_CHARS) w.data[8 * k +: 8] = pm_text[slot][c];
					end
					w.length = (pm_len[slot] > 15) ? LEN_MAX : 4'(pm_len[slot]);
					w.fix = 1'b1;
					w.last = 1'b0;
					rmc_words_due.push_back(w);
				end
				w.index = WORD_DIRS;
				w.data = {48'd0, pm_lon_dir, pm_lat_dir};
				w.length = DIRS_LEN;
				w.fix = 1'b1;
				w.last = 1'b1;
				rmc_words_due.push_back(w);
			end
			pm_pos = P_PREFIX;
			pm_count = 0;
			pm_failed = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] expv, input logic [63:0] actv);
		if (actv !== expv) begin
			$error("%s mismatch: expected %0h, actual %0h", name, expv, actv);
			error_count++;
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last, input bit drain, input bit burst);
		byte_req_t r;
		r.b = b;
		r.last = last;
		r.drain = drain;
		r.gap = burst ? 0 : pick_gap();
		byte_reqs.push_back(r);
		queued_items++;
	endtask

	// build one sentence from its shape, spoil it as asked, queue it
	task automatic emit_sentence(input rmc_spec_t sp, input rmc_flaw_t flaw, input bit drain,
			input bit burst);
		logic [7:0] s [$];
		int k, f, cut;
		case (flaw)
			FLAW_EMPTY_FIELD: sp.len[$urandom_range(0, 4)] = 5'd0;
			FLAW_LONG_FIELD:  sp.len[$urandom_range(0, 4)] = 5'(FIELD_CHARS + 1);
			FLAW_EMPTY_DATE:  sp.date_len = 4'd0;
			default: ;
		endcase
		for (k = 0; k < 7; k++) s.push_back(PREFIX_TEXT[8 * (6 - k) +: 8]);
		for (f = 0; f < SLOT_COUNT; f++) begin
			for (k = 0; k < int'(sp.len[f]); k++) s.push_back(text_char(sp.fill));
			s.push_back(CH_COMMA);
			if (f == 0) s.push_back(sp.status);
			if (f == 1) s.push_back(sp.lat_d);
			if (f == 2) s.push_back(sp.lon_d);
			if (f < 3) s.push_back(CH_COMMA);
		end
		for (k = 0; k < int'(sp.date_len); k++) s.push_back(text_char(CH_NUL));
		for (k = 0; k < 3; k++) s.push_back(CH_COMMA);
		s.push_back(sp.mode);
		for (k = 0; k < int'(sp.tail); k++) s.push_back(8'($urandom_range(0, 255)));
		case (flaw)
			FLAW_LITERAL: begin
				k = $urandom_range(0, 6);
				s[k] = s[k] ^ 8'($urandom_range(1, 255));
			end
			FLAW_ZERO: s[$urandom_range(0, s.size() - 1)] = CH_NUL;
			FLAW_EARLY_END: begin
				cut = $urandom_range(1, s.size() - 1 - int'(sp.tail));
				while (s.size() > cut) void'(s.pop_back());
			end
			default: ;
		endcase
		for (k = 0; k < s.size(); k++) push_byte(s[k], k == s.size() - 1, drain && k == 0, burst);
	endtask

	function automatic rmc_spec_t random_spec();
		rmc_spec_t sp;
		int f;
		for (f = 0; f < SLOT_COUNT; f++)
			sp.len[f] = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(8, FIELD_CHARS))
				: 5'($urandom_range(1, 4));
		sp.date_len = 4'($urandom_range(1, 6));
		sp.status = ($urandom_range(0, 99) < 85) ? CH_ACTIVE : 8'($urandom_range(0, 255));
		sp.lat_d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h4E;
		sp.lon_d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h57;
		f = $urandom_range(0, 9);
		sp.mode = (f < 8) ? 8'h44 : (f == 8) ? CH_NOFIX : 8'($urandom_range(0, 255));
		sp.tail = 3'($urandom_range(0, 3));
		sp.fill = CH_NUL;
		return sp;
	endfunction

	// request driver with random gaps and an optional wait for all words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tlast <= 1'b0;
			req_staged = 1'b0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) predict_rmc_item(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (!req_staged && byte_reqs.size() != 0) begin
					staged_req = byte_reqs.pop_front();
					req_staged = 1'b1;
					gap_left = staged_req.gap;
				end
				if (req_staged && gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (req_staged && !(staged_req.drain && rmc_words_due.size() != 0)) begin
					s_tvalid <= 1'b1;
					s_tdata <= staged_req.b;
					s_tlast <= staged_req.last;
					req_staged = 1'b0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		rmc_word_t w;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			rx_phase_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (rmc_words_due.size() == 0) begin
					$error("unexpected result word, word_index %0d", m_tdata[3:0]);
					error_count++;
				end else begin
					w = rmc_words_due.pop_front();
					check_field("word_index", 64'(w.index), 64'(m_tdata[3:0]));
					check_field("word_data", w.data, m_tdata[67:4]);
					check_field("text_length", 64'(w.length), 64'(m_tdata[71:68]));
					check_field("fix_valid", 64'(w.fix), 64'(m_tuser));
					check_field("last_word", 64'(w.last), 64'(m_tlast));
				end
			end
			// alternate stretches with and without stalls
			if (rx_phase_left == 0) begin
				rx_phase_left = $urandom_range(30, 300);
				rx_burst = ($urandom_range(0, 3) == 0);
			end else begin
				rx_phase_left--;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left = rx_burst ? 0 : pick_gap();
			end
		end
	end

	// stimulus and end of run
	initial begin
		rmc_spec_t sp;
		int k, n, r;
		pm_pos = P_PREFIX;
		pm_count = 0;
		pm_failed = 1'b0;
		pm_lat_dir = 8'h00;
		pm_lon_dir = 8'h00;
		pm_status = 8'h00;
		pm_mode = 8'h00;
		for (k = 0; k < SLOT_COUNT; k++) begin
			pm_len[k] = 0;
			for (n = 0; n < FIELD_CHARS; n++) pm_text[k][n] = 8'h00;
		end

		// full-length fields of 0xff, comma directions
		sp = '{len: {5{5'(FIELD_CHARS)}}, date_len: 4'd1, status: CH_ACTIVE, lat_d: CH_COMMA,
			lon_d: CH_COMMA, mode: 8'h41, tail: 3'd0, fill: 8'hFF};
		emit_sentence(sp, FLAW_NONE, 1'b0, 1'b0);
		// shortest fields of 0x01, no-fix mode, sent only after the previous run drained
		sp = '{len: {5{5'd1}}, date_len: 4'd1, status: CH_ACTIVE, lat_d: 8'h53, lon_d: 8'h45,
			mode: CH_NOFIX, tail: 3'd0, fill: 8'h01};
		emit_sentence(sp, FLAW_NONE, 1'b1, 1'b0);
		// status not active
		sp.status = 8'h56;
		sp.mode = 8'h41;
		emit_sentence(sp, FLAW_NONE, 1'b0, 1'b0);
		// end of sentence on the first byte, and a lone nul
		push_byte(8'h24, 1'b1, 1'b0, 1'b0);
		push_byte(CH_NUL, 1'b1, 1'b0, 1'b0);
		// good sentence with random trailing bytes after the mode
		sp = random_spec();
		sp.status = CH_ACTIVE;
		sp.mode = 8'h41;
		sp.tail = 3'd3;
		emit_sentence(sp, FLAW_NONE, 1'b0, 1'b1);
		emit_sentence(random_spec(), FLAW_LONG_FIELD, 1'b0, 1'b0);
		emit_sentence(random_spec(), FLAW_EMPTY_DATE, 1'b0, 1'b0);

		// random sentences up to the total byte count: mostly well formed, some broken, some noise
		while (queued_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				emit_sentence(random_spec(), FLAW_NONE, $urandom_range(0, 9) == 0,
					$urandom_range(0, 3) == 0);
			end else if (r < 90) begin
				emit_sentence(random_spec(), rmc_flaw_t'($urandom_range(1, 6)),
					$urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0);
			end else begin
				n = $urandom_range(1, 8);
				for (k = 0; k < n; k++)
					push_byte(8'($urandom_range(0, 255)), k == n - 1, 1'b0, 1'b0);
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all requests, then all words, then a short drain
		while (byte_reqs.size() != 0 || req_staged || s_tvalid) @(posedge clk);
		while (rmc_words_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
